/* rtl/core/swtp_pkg.sv */
// ============================================================================
// swtp_pkg: shared types and constants for the swarm transition update
// Fixed-point constants, register indexes and pipeline stage records.
// ============================================================================
package swtp_pkg;

    localparam int unsigned AMP_W    = 17;     // Q1.16 amplitude, 1.0 included
    localparam int unsigned GAIN_W   = 16;     // Q4.12 gain
    localparam int unsigned POS_W    = 10;     // discrete position / range limit
    localparam int unsigned FRAC_W   = 16;     // quotient bits per long division
    localparam int unsigned DEN_W    = 18;     // normalizing sum width
    localparam int unsigned IDX_W    = 3;      // configuration register index

    localparam logic [AMP_W-1:0] ONE_Q16 = 17'h10000;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_INERTIA   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COGNITIVE = 3'd1;
    localparam logic [IDX_W-1:0] REG_SOCIAL    = 3'd2;
    localparam logic [IDX_W-1:0] REG_STAY_AMP  = 3'd3;
    localparam logic [IDX_W-1:0] REG_STAY_PROB = 3'd4;

    // Record carried through the up-amplitude divider
    typedef struct packed {
        logic               zero;     // numerator not positive
        logic               sat;      // quotient reaches 1.0
        logic [POS_W-1:0]   rem;      // partial remainder, below the limit
        logic [FRAC_W-1:0]  num_lo;   // dividend bits still to shift in
        logic [FRAC_W-1:0]  quo;      // quotient bits so far
        logic [POS_W-1:0]   lim;      // divisor
        logic               last;
    } up_stage_t;

    // Record carried through the two probability dividers
    typedef struct packed {
        logic               dz;       // zero normalizing sum
        logic               fu;       // up amplitude equals the sum
        logic               fd;       // down amplitude equals the sum
        logic [DEN_W-1:0]   rem_u;
        logic [DEN_W-1:0]   rem_d;
        logic [FRAC_W-1:0]  quo_u;
        logic [FRAC_W-1:0]  quo_d;
        logic [DEN_W-1:0]   den;
        logic [AMP_W-1:0]   up;
        logic [AMP_W-1:0]   down;
        logic               last;
    } prob_stage_t;

endpackage

/* rtl/core/swarm_transition_probability_update.sv */
// ============================================================================
// swarm_transition_probability_update: discrete swarm move probabilities
// Pipelined update of one particle dimension per beat: new up and down
// amplitudes and their normalized move probabilities.
// ============================================================================
//  channel   group              payload
//  input     s_axis_t*          tdata: old_up_amp, current_position,
//                               personal_best_position, swarm_best_position,
//                               range_limit; tlast: last_of_particle
//  output    m_axis_t*          tdata: new_up_amp, new_down_amp,
//                               up_probability, down_probability;
//                               tlast: end_of_particle
//  config    cfg_we/index/wdata write-only gain and stay registers
//
//  One beat enters per cycle unless the output beat is held. The pipe has
//  3 front stages, 16 up-amplitude division steps, 1 down/sum stage,
//  16 probability steps and 1 output register. The whole pipe advances
//  together: when the output beat is held, every stage holds and s_axis_tready
//  drops. Reset clears the valid bits and loads the register defaults.
// ============================================================================
module swarm_transition_probability_update (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [16:0] old_up_amp, [26:17] current_position,
    // [36:27] personal_best_position, [46:37] swarm_best_position,
    // [56:47] range_limit, [63:57] zero
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [16:0] new_up_amp, [33:17] new_down_amp, [50:34] up_probability,
    // [67:51] down_probability, [71:68] zero
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wdata
);

    localparam int unsigned STEPS = swtp_pkg::FRAC_W;

    logic [15:0] inertia_reg, cognitive_reg, social_reg;
    logic [16:0] stay_amp_reg, stay_prob_reg;

    logic adv;

    logic                 up_vld_reg [0:STEPS];
    swtp_pkg::up_stage_t  up_reg     [0:STEPS];
    logic                 pr_vld_reg [0:STEPS];
    swtp_pkg::prob_stage_t pr_reg    [0:STEPS];

    logic                 front_vld;
    swtp_pkg::up_stage_t  front_stage;
    swtp_pkg::prob_stage_t norm_next;

    logic        out_vld_reg;
    logic [71:0] out_data_reg, out_data_next;
    logic        out_last_reg;

    logic [16:0]        up_amp;
    logic signed [18:0] down_diff;
    logic [16:0]        down_amp;
    logic [17:0]        den;
    logic [16:0]        prob_u, prob_d;

    // Global stall: every stage moves when the output beat can move
    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_reg   <= 16'd4096;
            cognitive_reg <= 16'd4096;
            social_reg    <= 16'd4096;
            stay_amp_reg  <= 17'd0;
            stay_prob_reg <= 17'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swtp_pkg::REG_INERTIA:   inertia_reg   <= cfg_wdata[15:0];
                swtp_pkg::REG_COGNITIVE: cognitive_reg <= cfg_wdata[15:0];
                swtp_pkg::REG_SOCIAL:    social_reg    <= cfg_wdata[15:0];
                swtp_pkg::REG_STAY_AMP:  stay_amp_reg  <= cfg_wdata;
                swtp_pkg::REG_STAY_PROB: stay_prob_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    swtp_front u_front (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .adv                    (adv),
        .in_vld                 (s_axis_tvalid),
        .old_up_amp             (s_axis_tdata[16:0]),
        .current_position       (s_axis_tdata[26:17]),
        .personal_best_position (s_axis_tdata[36:27]),
        .swarm_best_position    (s_axis_tdata[46:37]),
        .range_limit            (s_axis_tdata[56:47]),
        .last_of_particle       (s_axis_tlast),
        .inertia_gain           (inertia_reg),
        .cognitive_gain         (cognitive_reg),
        .social_gain            (social_reg),
        .out_vld                (front_vld),
        .out_stage              (front_stage)
    );

    always_comb
    begin
        up_vld_reg[0] = front_vld;
        up_reg[0]     = front_stage;
    end

    // Up-amplitude divider: one quotient bit per stage
    genvar gi;
    generate
        for (gi = 0; gi < STEPS; gi++)
        begin : g_up
            logic [9:0]          rem_o;
            logic                qb;
            swtp_pkg::up_stage_t nxt;
            logic                vld_r;
            swtp_pkg::up_stage_t st_r;

            swtp_div_step #(.W(swtp_pkg::POS_W)) u_step (
                .rem     (up_reg[gi].rem),
                .nb      (up_reg[gi].num_lo[15]),
                .dvs     (up_reg[gi].lim),
                .rem_out (rem_o),
                .qbit    (qb)
            );

            always_comb
            begin
                nxt        = up_reg[gi];
                nxt.rem    = rem_o;
                nxt.num_lo = {up_reg[gi].num_lo[14:0], 1'b0};
                nxt.quo    = {up_reg[gi].quo[14:0], qb};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_r <= 1'b0;
                end
                else if (adv)
                begin
                    vld_r <= up_vld_reg[gi];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    st_r <= nxt;
                end
            end

            always_comb
            begin
                up_vld_reg[gi+1] = vld_r;
                up_reg[gi+1]     = st_r;
            end
        end
    endgenerate

    // Clamp up amplitude, form down amplitude and the normalizing sum
    always_comb
    begin
        if (up_reg[STEPS].zero)
            up_amp = '0;
        else if (up_reg[STEPS].sat)
            up_amp = swtp_pkg::ONE_Q16;
        else
            up_amp = {1'b0, up_reg[STEPS].quo};
        down_diff = $signed({2'b0, swtp_pkg::ONE_Q16}) - $signed({2'b0, up_amp})
                    - $signed({2'b0, stay_amp_reg});
        down_amp  = down_diff[18] ? 17'd0 : down_diff[16:0];
        den       = 18'(up_amp) + 18'(down_amp) + 18'(stay_prob_reg);

        norm_next.dz    = (den == 18'd0);
        norm_next.fu    = (18'(up_amp) >= den);
        norm_next.fd    = (18'(down_amp) >= den);
        norm_next.rem_u = 18'(up_amp);
        norm_next.rem_d = 18'(down_amp);
        norm_next.quo_u = '0;
        norm_next.quo_d = '0;
        norm_next.den   = den;
        norm_next.up    = up_amp;
        norm_next.down  = down_amp;
        norm_next.last  = up_reg[STEPS].last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            pr_vld_reg[0] <= up_vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg[0] <= norm_next;
        end
    end

    // Probability dividers: one bit of each quotient per stage
    generate
        for (gi = 0; gi < STEPS; gi++)
        begin : g_pr
            logic [17:0]           rem_uo, rem_do;
            logic                  qbu, qbd;
            swtp_pkg::prob_stage_t nxt;

            swtp_div_step #(.W(swtp_pkg::DEN_W)) u_step_u (
                .rem     (pr_reg[gi].rem_u),
                .nb      (1'b0),
                .dvs     (pr_reg[gi].den),
                .rem_out (rem_uo),
                .qbit    (qbu)
            );

            swtp_div_step #(.W(swtp_pkg::DEN_W)) u_step_d (
                .rem     (pr_reg[gi].rem_d),
                .nb      (1'b0),
                .dvs     (pr_reg[gi].den),
                .rem_out (rem_do),
                .qbit    (qbd)
            );

            always_comb
            begin
                nxt       = pr_reg[gi];
                nxt.rem_u = rem_uo;
                nxt.rem_d = rem_do;
                nxt.quo_u = {pr_reg[gi].quo_u[14:0], qbu};
                nxt.quo_d = {pr_reg[gi].quo_d[14:0], qbd};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pr_vld_reg[gi+1] <= 1'b0;
                end
                else if (adv)
                begin
                    pr_vld_reg[gi+1] <= pr_vld_reg[gi];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    pr_reg[gi+1] <= nxt;
                end
            end
        end
    endgenerate

    // Select final probabilities and pack the output beat
    always_comb
    begin
        if (pr_reg[STEPS].dz)
            prob_u = '0;
        else if (pr_reg[STEPS].fu)
            prob_u = swtp_pkg::ONE_Q16;
        else
            prob_u = {1'b0, pr_reg[STEPS].quo_u};
        if (pr_reg[STEPS].dz)
            prob_d = '0;
        else if (pr_reg[STEPS].fd)
            prob_d = swtp_pkg::ONE_Q16;
        else
            prob_d = {1'b0, pr_reg[STEPS].quo_d};
        out_data_next = {4'd0, prob_d, prob_u, pr_reg[STEPS].down, pr_reg[STEPS].up};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= pr_vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= pr_reg[STEPS].last;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* rtl/core/swtp_div_step.sv */
// ============================================================================
// swtp_div_step: one restoring long-division step
// Shifts one dividend bit into the remainder and subtracts the divisor if it
// fits, giving one quotient bit.
// ============================================================================
module swtp_div_step #(
    parameter int unsigned W = 10
) (
    input  logic [W-1:0] rem,
    input  logic         nb,
    input  logic [W-1:0] dvs,
    output logic [W-1:0] rem_out,
    output logic         qbit
);

    logic [W:0] trial;
    logic [W:0] diff;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial   = {rem, nb};
        diff    = trial - {1'b0, dvs};
        qbit    = (trial >= {1'b0, dvs});
        rem_out = qbit ? diff[W-1:0] : trial[W-1:0];
    end

endmodule

/* rtl/core/swtp_front.sv */
// ============================================================================
// swtp_front: gain products and scaled dividend for the up amplitude
// Three register stages: gain multiplies, limit multiply and pull sum, then
// the dividend floor(S/4096) with zero and saturation flags.
// ============================================================================
module swtp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_vld,
    input  logic [swtp_pkg::AMP_W-1:0]    old_up_amp,
    input  logic [swtp_pkg::POS_W-1:0]    current_position,
    input  logic [swtp_pkg::POS_W-1:0]    personal_best_position,
    input  logic [swtp_pkg::POS_W-1:0]    swarm_best_position,
    input  logic [swtp_pkg::POS_W-1:0]    range_limit,
    input  logic                          last_of_particle,
    input  logic [swtp_pkg::GAIN_W-1:0]   inertia_gain,
    input  logic [swtp_pkg::GAIN_W-1:0]   cognitive_gain,
    input  logic [swtp_pkg::GAIN_W-1:0]   social_gain,
    output logic                          out_vld,
    output swtp_pkg::up_stage_t           out_stage
);

    logic [2:0]          vld_reg;

    logic [32:0]         prod_io_reg, prod_io_next;
    logic signed [27:0]  cpull_reg, cpull_next;
    logic signed [27:0]  spull_reg, spull_next;
    logic [9:0]          lim1_reg, lim1_next;
    logic                last1_reg;

    logic [42:0]         a_reg, a_next;
    logic signed [28:0]  pull_reg, pull_next;
    logic [9:0]          lim2_reg;
    logic                last2_reg;

    swtp_pkg::up_stage_t st3_reg, st3_next;

    logic signed [27:0]  cog_s, soc_s, dpb_s, dgb_s;
    logic signed [33:0]  q1;

    // Stage 1: gain products
    always_comb
    begin
        lim1_next    = (range_limit == 10'd0) ? 10'd1 : range_limit;
        prod_io_next = 33'(inertia_gain) * 33'(old_up_amp);
        cog_s        = $signed({12'd0, cognitive_gain});
        soc_s        = $signed({12'd0, social_gain});
        dpb_s        = $signed({18'd0, personal_best_position})
                       - $signed({18'd0, current_position});
        dgb_s        = $signed({18'd0, swarm_best_position})
                       - $signed({18'd0, current_position});
        cpull_next   = cog_s * dpb_s;
        spull_next   = soc_s * dgb_s;
    end

    // Stage 2: scale inertia term by the limit, sum the pulls
    always_comb
    begin
        a_next    = 43'(prod_io_reg) * 43'(lim1_reg);
        pull_next = 29'(cpull_reg) + 29'(spull_reg);
    end

    // Stage 3: dividend floor(S/4096) and range flags
    always_comb
    begin
        q1 = $signed({3'd0, a_reg[42:12]}) + ($signed(34'(pull_reg)) <<< 4);
        st3_next.zero   = q1[33] || (q1 == 34'sd0);
        st3_next.sat    = (q1[32:0] >= {7'd0, lim2_reg, 16'd0});
        st3_next.rem    = q1[25:16];
        st3_next.num_lo = q1[15:0];
        st3_next.quo    = '0;
        st3_next.lim    = lim2_reg;
        st3_next.last   = last2_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_io_reg <= prod_io_next;
            cpull_reg   <= cpull_next;
            spull_reg   <= spull_next;
            lim1_reg    <= lim1_next;
            last1_reg   <= last_of_particle;
            a_reg       <= a_next;
            pull_reg    <= pull_next;
            lim2_reg    <= lim1_reg;
            last2_reg   <= last1_reg;
            st3_reg     <= st3_next;
        end
    end

    assign out_vld   = vld_reg[2];
    assign out_stage = st3_reg;

endmodule
